### rtl/ibp_pkg.sv
// Shared types, constants and the per-axis coordinate mapping for the border padder.
package ibp_pkg;

   localparam int MAX_DIM = 64;
   localparam int ELEM_W  = 32;
   localparam int DIM_W   = 7;
   localparam int CFG_W   = 32;
   localparam int IDX_W   = $clog2(MAX_DIM);
   localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DIM);
   localparam int COORD_W = $clog2(3 * MAX_DIM);
   localparam int SUM_W   = COORD_W + 1;
   localparam int SW      = COORD_W + 2;
   localparam int REG_W   = 3;

   typedef enum logic [1:0] {
      MODE_CONST     = 2'd0,
      MODE_REPLICATE = 2'd1,
      MODE_REFLECT   = 2'd2
   } mode_type;

   typedef enum logic [REG_W-1:0] {
      REG_SRC_WIDTH   = 3'd0,
      REG_SRC_HEIGHT  = 3'd1,
      REG_PAD_TOP     = 3'd2,
      REG_PAD_BOTTOM  = 3'd3,
      REG_PAD_LEFT    = 3'd4,
      REG_PAD_RIGHT   = 3'd5,
      REG_BORDER_MODE = 3'd6,
      REG_PAD_VALUE   = 3'd7
   } reg_index_type;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EMIT = 1'b1;

   typedef struct packed {
      logic              we;
      logic              re;
      logic [ADDR_W-1:0] addr;
      logic [ELEM_W-1:0] wdata;
   } mem_cmd_type;

   typedef struct packed {
      logic              fill;
      logic              last;
      logic [ELEM_W-1:0] pad;
   } emit_info_type;

   typedef struct packed {
      logic             in_image;
      logic [IDX_W-1:0] idx;
   } axis_map_type;

   // Maps an output coordinate on one axis to a source index. Reflect mirrors
   // without repeating the edge; whatever still falls outside is clamped.
   function automatic axis_map_type map_axis(input logic [COORD_W-1:0] o,
                                             input logic [DIM_W-1:0]   pad,
                                             input logic [DIM_W-1:0]   n,
                                             input logic [1:0]         mode);
      axis_map_type     res;
      logic signed [SW-1:0] s;
      logic signed [SW-1:0] last;
      s    = $signed({{(SW-COORD_W){1'b0}}, o}) - $signed({{(SW-DIM_W){1'b0}}, pad});
      last = $signed({{(SW-DIM_W){1'b0}}, n}) - SW'(1);
      res.in_image = 1'b1;
      case (mode)
         MODE_REPLICATE: begin
         end
         MODE_REFLECT: begin
            if (s < 0) s = -s;
            if (s > last) s = last + last - s;
         end
         default: begin
            if (s < 0 || s > last) res.in_image = 1'b0;
         end
      endcase
      if (s < 0) s = '0;
      if (s > last) s = last;
      res.idx = s[IDX_W-1:0];
      return res;
   endfunction

endpackage

### rtl/image_border_padding.sv
// Border padder for one image channel: loads source elements into a 4096-word store and streams
// out the padded image in raster order with constant, replicate or reflect borders. One request
// is accepted per cycle while the response path moves. An emit request reads the store into
// the read stage at its accepting edge and moves on into the output register once that register
// is free. With responses held off, the read stage and the output register hold two responses,
// and then req_tready drops until the output is taken. Load requests give no response. The store
// needs no clearing after reset; only loaded entries are ever read by a valid image.
module image_border_padding (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ibp_pkg::ELEM_W-1:0]       req_tdata,   // pixel_value
   input  logic [0:0]                       req_tuser,   // req_type
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ibp_pkg::ELEM_W-1:0]       rsp_tdata,   // out_value
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [ibp_pkg::REG_W-1:0]        csr_index,
   input  logic [ibp_pkg::CFG_W-1:0]        csr_wdata
);

   ibp_pkg::mem_cmd_type       mem_cmd;
   ibp_pkg::emit_info_type     emit_info;
   logic [ibp_pkg::ELEM_W-1:0] rd_data;
   logic                       req_acc, rsp_free, s1_move;

   logic                       s1_vld_ff, s1_vld_in;
   logic                       s1_fill_ff, s1_last_ff;
   logic [ibp_pkg::ELEM_W-1:0] s1_pad_ff;
   logic                       rsp_vld_ff, rsp_vld_in;
   logic                       rsp_last_ff;
   logic [ibp_pkg::ELEM_W-1:0] rsp_data_ff;

   assign rsp_free   = !rsp_vld_ff || rsp_tready;
   assign s1_move    = s1_vld_ff && rsp_free;
   assign req_tready = !s1_vld_ff || rsp_free;
   assign req_acc    = req_tvalid && req_tready;

   ibp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_acc   (req_acc),
      .req_kind  (req_tuser[0]),
      .req_pixel (req_tdata),
      .mem_cmd   (mem_cmd),
      .emit_info (emit_info)
   );

   ibp_store u_store (
      .clock   (clock),
      .cmd     (mem_cmd),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (s1_move) s1_vld_in = 1'b0;
      if (mem_cmd.re) s1_vld_in = 1'b1;
      rsp_vld_in = rsp_vld_ff;
      if (rsp_vld_ff && rsp_tready) rsp_vld_in = 1'b0;
      if (s1_move) rsp_vld_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // The read data register holds while the first stage is stalled, since no new read is issued.
   always_ff @(posedge clock) begin
      if (mem_cmd.re) begin
         s1_fill_ff <= emit_info.fill;
         s1_last_ff <= emit_info.last;
         s1_pad_ff  <= emit_info.pad;
      end
      if (s1_move) begin
         rsp_data_ff <= s1_fill_ff ? s1_pad_ff : rd_data;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### rtl/ibp_store.sv
// Image store: one synchronous single-port memory with registered read data.
module ibp_store (
   input  logic                        clock,
   input  ibp_pkg::mem_cmd_type        cmd,
   output logic [ibp_pkg::ELEM_W-1:0]  rd_data
);

   logic [ibp_pkg::ELEM_W-1:0] mem [ibp_pkg::MAX_DIM * ibp_pkg::MAX_DIM];
   logic [ibp_pkg::ELEM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.addr] <= cmd.wdata;
      end
      if (cmd.re) begin
         rd_data_ff <= mem[cmd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ibp_ctrl.sv
// Configuration registers, load pointer, emit raster counters and store address generation.
module ibp_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [ibp_pkg::REG_W-1:0]     csr_index,
   input  logic [ibp_pkg::CFG_W-1:0]     csr_wdata,
   input  logic                          req_acc,
   input  logic                          req_kind,
   input  logic [ibp_pkg::ELEM_W-1:0]    req_pixel,
   output ibp_pkg::mem_cmd_type          mem_cmd,
   output ibp_pkg::emit_info_type        emit_info
);

   logic [ibp_pkg::DIM_W-1:0]   width_ff, height_ff, top_ff, bottom_ff, left_ff, right_ff;
   logic [1:0]                  mode_ff;
   logic [ibp_pkg::ELEM_W-1:0]  pad_value_ff;
   logic [ibp_pkg::ADDR_W-1:0]  ptr_ff, ptr_in;
   logic [ibp_pkg::COORD_W-1:0] col_ff, col_in, row_ff, row_in;

   logic [ibp_pkg::DIM_W-1:0]   size_w, pad_w;
   logic [ibp_pkg::SUM_W-1:0]   out_w, out_h, col_nx, row_nx;
   logic                        col_end, row_end, is_last;
   ibp_pkg::axis_map_type       map_x, map_y;
   logic [ibp_pkg::ADDR_W-1:0]  addr_full;

   // Sizes are held already clamped: zero acts as one, anything above the limit saturates.
   always_comb begin
      size_w = csr_wdata[ibp_pkg::DIM_W-1:0];
      if (size_w == '0) size_w = ibp_pkg::DIM_W'(1);
      if (size_w > ibp_pkg::DIM_W'(ibp_pkg::MAX_DIM)) size_w = ibp_pkg::DIM_W'(ibp_pkg::MAX_DIM);
      pad_w = csr_wdata[ibp_pkg::DIM_W-1:0];
      if (pad_w > ibp_pkg::DIM_W'(ibp_pkg::MAX_DIM)) pad_w = ibp_pkg::DIM_W'(ibp_pkg::MAX_DIM);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= ibp_pkg::DIM_W'(1);
         height_ff    <= ibp_pkg::DIM_W'(1);
         top_ff       <= '0;
         bottom_ff    <= '0;
         left_ff      <= '0;
         right_ff     <= '0;
         mode_ff      <= ibp_pkg::MODE_CONST;
         pad_value_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ibp_pkg::REG_SRC_WIDTH:   width_ff     <= size_w;
            ibp_pkg::REG_SRC_HEIGHT:  height_ff    <= size_w;
            ibp_pkg::REG_PAD_TOP:     top_ff       <= pad_w;
            ibp_pkg::REG_PAD_BOTTOM:  bottom_ff    <= pad_w;
            ibp_pkg::REG_PAD_LEFT:    left_ff      <= pad_w;
            ibp_pkg::REG_PAD_RIGHT:   right_ff     <= pad_w;
            ibp_pkg::REG_BORDER_MODE: mode_ff      <= csr_wdata[1:0];
            ibp_pkg::REG_PAD_VALUE:   pad_value_ff <= csr_wdata[ibp_pkg::ELEM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      out_w   = ibp_pkg::SUM_W'(width_ff) + ibp_pkg::SUM_W'(left_ff) + ibp_pkg::SUM_W'(right_ff);
      out_h   = ibp_pkg::SUM_W'(height_ff) + ibp_pkg::SUM_W'(top_ff) + ibp_pkg::SUM_W'(bottom_ff);
      col_nx  = ibp_pkg::SUM_W'(col_ff) + ibp_pkg::SUM_W'(1);
      row_nx  = ibp_pkg::SUM_W'(row_ff) + ibp_pkg::SUM_W'(1);
      col_end = col_nx >= out_w;
      row_end = row_nx >= out_h;
      is_last = col_end && row_end;

      map_x = ibp_pkg::map_axis(col_ff, left_ff, width_ff, mode_ff);
      map_y = ibp_pkg::map_axis(row_ff, top_ff, height_ff, mode_ff);
      addr_full = ibp_pkg::ADDR_W'(map_y.idx) * ibp_pkg::ADDR_W'(width_ff)
                + ibp_pkg::ADDR_W'(map_x.idx);

      ptr_in = ptr_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (csr_we) begin
         ptr_in = '0;
         col_in = '0;
         row_in = '0;
      end else if (req_acc) begin
         if (req_kind == ibp_pkg::REQ_LOAD) begin
            ptr_in = ptr_ff + ibp_pkg::ADDR_W'(1);
         end else if (is_last) begin
            ptr_in = '0;
            col_in = '0;
            row_in = '0;
         end else if (col_end) begin
            col_in = '0;
            row_in = row_nx[ibp_pkg::COORD_W-1:0];
         end else begin
            col_in = col_nx[ibp_pkg::COORD_W-1:0];
         end
      end

      mem_cmd.we    = req_acc && (req_kind == ibp_pkg::REQ_LOAD);
      mem_cmd.re    = req_acc && (req_kind == ibp_pkg::REQ_EMIT);
      mem_cmd.addr  = (req_kind == ibp_pkg::REQ_LOAD) ? ptr_ff : addr_full;
      mem_cmd.wdata = req_pixel;

      emit_info.fill = !(map_x.in_image && map_y.in_image);
      emit_info.last = is_last;
      emit_info.pad  = pad_value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

### tb/testbench.sv
// Self-checking testbench for the image border padder: random images, borders and stalls.
`timescale 1ns / 1ps

module testbench;
   import ibp_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct {
      logic              kind;
      logic [ELEM_W-1:0] pixel;
   } pad_request_t;

   typedef struct {
      logic [ELEM_W-1:0] value;
      logic              last;
   } padded_elem_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ELEM_W-1:0]   req_tdata = '0;   // pixel_value
   logic [0:0]          req_tuser = '0;   // req_type
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [ELEM_W-1:0]   rsp_tdata;        // out_value
   logic                rsp_tlast;
   logic                csr_we = 1'b0;
   logic [REG_W-1:0]    csr_index = '0;
   logic [CFG_W-1:0]    csr_wdata = '0;

   image_border_padding DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   pad_request_t request_q[$];
   padded_elem_t padded_q[$];
   int           stim_count = 0;
   int           req_count = 0;
   int           rsp_count = 0;
   int           mismatches = 0;
   bit           req_taken = 1'b0;
   int           stall_left = 0;
   int           next_stall_at = 300;

   // Shadow of the block: registers, source store and raster position.
   logic [DIM_W-1:0]  cfg_src_w = 7'd1;
   logic [DIM_W-1:0]  cfg_src_h = 7'd1;
   logic [DIM_W-1:0]  cfg_pad_t = '0;
   logic [DIM_W-1:0]  cfg_pad_b = '0;
   logic [DIM_W-1:0]  cfg_pad_l = '0;
   logic [DIM_W-1:0]  cfg_pad_r = '0;
   logic [1:0]        cfg_mode = MODE_CONST;
   logic [ELEM_W-1:0] cfg_fill = '0;
   logic [ELEM_W-1:0] image_mem [0:MAX_DIM*MAX_DIM-1];
   logic [ADDR_W-1:0] load_ptr = '0;
   int                emit_col = 0;
   int                emit_row = 0;

   function automatic int eff_size(input logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
   endfunction

   function automatic int eff_pad(input logic [DIM_W-1:0] v);
      return (v > MAX_DIM) ? MAX_DIM : v;
   endfunction

   // Source index for output coordinate o on one axis; fill is set for a constant border.
   function automatic int fold_axis(input int o, input int pad, input int n, output bit fill);
      int s;
      s = o - pad;
      fill = 1'b0;
      case (cfg_mode)
         MODE_REPLICATE: ;
         MODE_REFLECT: begin
            if (s < 0) s = -s;
            if (s > n - 1) s = 2 * (n - 1) - s;
         end
         default: fill = (s < 0 || s > n - 1);
      endcase
      if (s < 0) s = 0;
      if (s > n - 1) s = n - 1;
      return s;
   endfunction

   task automatic apply_border_request(input logic kind, input logic [ELEM_W-1:0] pixel);
      int           w, h, out_w, out_h, sx, sy;
      bit           fill_x, fill_y;
      padded_elem_t res;
      w = eff_size(cfg_src_w);
      h = eff_size(cfg_src_h);
      if (kind == REQ_LOAD) begin
         image_mem[load_ptr] = pixel;
         load_ptr = load_ptr + 1'b1;
      end else begin
         out_w = w + eff_pad(cfg_pad_l) + eff_pad(cfg_pad_r);
         out_h = h + eff_pad(cfg_pad_t) + eff_pad(cfg_pad_b);
         sx = fold_axis(emit_col, eff_pad(cfg_pad_l), w, fill_x);
         sy = fold_axis(emit_row, eff_pad(cfg_pad_t), h, fill_y);
         res.value = (fill_x || fill_y) ? cfg_fill : image_mem[sy * w + sx];
         res.last = (emit_row + 1 >= out_h) && (emit_col + 1 >= out_w);
         padded_q.push_back(res);
         if (res.last) begin
            emit_col = 0;
            emit_row = 0;
            load_ptr = '0;
         end else if (emit_col + 1 >= out_w) begin
            emit_col = 0;
            emit_row++;
         end else begin
            emit_col++;
         end
      end
   endtask

   function automatic void note_reg_write(input reg_index_type idx, input logic [CFG_W-1:0] val);
      case (idx)
         REG_SRC_WIDTH:   cfg_src_w = val[DIM_W-1:0];
         REG_SRC_HEIGHT:  cfg_src_h = val[DIM_W-1:0];
         REG_PAD_TOP:     cfg_pad_t = val[DIM_W-1:0];
         REG_PAD_BOTTOM:  cfg_pad_b = val[DIM_W-1:0];
         REG_PAD_LEFT:    cfg_pad_l = val[DIM_W-1:0];
         REG_PAD_RIGHT:   cfg_pad_r = val[DIM_W-1:0];
         REG_BORDER_MODE: cfg_mode = val[1:0];
         default:         cfg_fill = val[ELEM_W-1:0];
      endcase
      load_ptr = '0;
      emit_col = 0;
      emit_row = 0;
   endfunction

   // Request side: capture accepted requests and predict their responses.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         apply_border_request(req_tuser[0], req_tdata);
         req_taken = 1'b1;
         req_count++;
      end
   end

   always @(negedge clock) begin : send_requests
      pad_request_t nxt;
      bit           steady;
      steady = (req_count >= 600 && req_count < 1000);
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (request_q.size() != 0 && (steady || $urandom_range(99) >= 37)) begin
            nxt = request_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= nxt.pixel;
            req_tuser <= nxt.kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      req_taken = 1'b0;
   end

   // Response side: ready with random gaps, plus a long hold-off while requests are queued.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_count >= next_stall_at && request_q.size() > 40) begin
         stall_left = 250;
         next_stall_at += 1500;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (rsp_count >= 700 && rsp_count < 1100) || $urandom_range(99) >= 37;
      end
   end

   always @(posedge clock) begin : check_responses
      padded_elem_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (padded_q.size() == 0) begin
            if (mismatches < 40)
               $display("%0t: unexpected response: expected none, actual value %h last %b",
                        $time, rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            want = padded_q.pop_front();
            if (rsp_tdata !== want.value) begin
               if (mismatches < 40)
                  $display("%0t: out_value mismatch: expected %h, actual %h",
                           $time, want.value, rsp_tdata);
               mismatches++;
            end
            if (rsp_tlast !== want.last) begin
               if (mismatches < 40)
                  $display("%0t: out_last mismatch: expected %b, actual %b",
                           $time, want.last, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   task automatic push_req(input logic kind, input logic [ELEM_W-1:0] pixel);
      request_q.push_back('{kind, pixel});
      stim_count++;
   endtask

   task automatic wait_results();
      while (request_q.size() != 0 || req_tvalid || padded_q.size() != 0)
         @(negedge clock);
   endtask

   // A trailing load gives no response, so allow for the pipeline before touching registers.
   task automatic settle();
      wait_results();
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [CFG_W-1:0] with_junk(input logic [CFG_W-1:0] v, input int keep);
      logic [CFG_W-1:0] m;
      m = ~({CFG_W{1'b1}} << keep);
      return ($urandom_range(1) == 1) ? ((v & m) | ($urandom & ~m)) : (v & m);
   endfunction

   // Called at a falling edge; returns at the next one.
   task automatic write_reg(input reg_index_type idx, input logic [CFG_W-1:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      note_reg_write(idx, val);
      @(negedge clock);
   endtask

   task automatic configure(input int w, input int h, input int pt, input int pb,
                            input int pl, input int pr, input logic [1:0] mode,
                            input logic [CFG_W-1:0] fill);
      settle();
      write_reg(REG_SRC_WIDTH, with_junk(w, DIM_W));
      write_reg(REG_SRC_HEIGHT, with_junk(h, DIM_W));
      write_reg(REG_PAD_TOP, with_junk(pt, DIM_W));
      write_reg(REG_PAD_BOTTOM, with_junk(pb, DIM_W));
      write_reg(REG_PAD_LEFT, with_junk(pl, DIM_W));
      write_reg(REG_PAD_RIGHT, with_junk(pr, DIM_W));
      write_reg(REG_BORDER_MODE, with_junk(mode, 2));
      write_reg(REG_PAD_VALUE, fill);
      csr_we = 1'b0;
   endtask

   // Loads one source image and emits its padded version; a partial image stops early.
   task automatic queue_image(input bit partial);
      int n_load, n_emit, i;
      n_load = eff_size(cfg_src_w) * eff_size(cfg_src_h);
      n_emit = (eff_size(cfg_src_w) + eff_pad(cfg_pad_l) + eff_pad(cfg_pad_r)) *
               (eff_size(cfg_src_h) + eff_pad(cfg_pad_t) + eff_pad(cfg_pad_b));
      for (i = 0; i < n_load; i++)
         push_req(REQ_LOAD, $urandom);
      if ($urandom_range(7) == 0)
         wait_results();
      if (partial && n_emit > 1)
         n_emit = $urandom_range(n_emit - 1, 1);
      for (i = 0; i < n_emit; i++) begin
         if ($urandom_range(11) == 0)
            push_req(REQ_LOAD, $urandom);
         push_req(REQ_EMIT, $urandom);
      end
   endtask

   initial begin : stimulus
      int               phase, images, i;
      logic [1:0]       mode;
      logic [CFG_W-1:0] fill;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: a single element image, twice, with extreme values.
      push_req(REQ_LOAD, 32'hFFFF_FFFF);
      push_req(REQ_EMIT, 32'h0000_0000);
      push_req(REQ_LOAD, 32'h0000_0000);
      push_req(REQ_EMIT, 32'hFFFF_FFFF);
      // Zero width and a reflected pad deeper than the image.
      configure(0, 2, 3, 0, 0, 0, MODE_REFLECT, 32'h0);
      queue_image(1'b0);
      // The unused mode pads with the constant; the partial image is cut by the next write.
      configure(2, 1, 0, 0, 1, 1, MODE_UNUSED, 32'hA5A5_5A5A);
      queue_image(1'b0);
      queue_image(1'b1);

      phase = 0;
      while (stim_count < 1425) begin
         mode = ($urandom_range(9) == 0) ? MODE_UNUSED : 2'($urandom_range(2));
         fill = ($urandom_range(7) == 0) ? 32'h0 :
                ($urandom_range(7) == 0) ? 32'hFFFF_FFFF : 32'($urandom);
         case (phase)
            1: configure(64, 1, 0, 0, 64, 64, MODE_REFLECT, fill);
            3: configure(1, 64, 127, 64, 0, 0, MODE_REPLICATE, fill);
            5: configure(127, 0, 1, 1, 127, 64, MODE_CONST, 32'hFFFF_FFFF);
            default: configure($urandom_range(8, 0), $urandom_range(6, 0),
                               $urandom_range(4, 0), $urandom_range(4, 0),
                               $urandom_range(4, 0), $urandom_range(4, 0), mode, fill);
         endcase
         images = (phase % 2 == 1 && phase < 8) ? 1 : $urandom_range(3, 1);
         for (i = 0; i < images; i++)
            queue_image(i == images - 1 && $urandom_range(5) == 0);
         phase++;
      end

      settle();
      if (mismatches == 0)
         $display("** image_border_padding: PASSED **");
      else
         $display("** image_border_padding: FAILED **");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("** image_border_padding: FAILED **");
      $finish;
   end

endmodule
